// ----- src/qoa_pkg.sv -----
// Package for the quaternion orientation accumulator.
// Holds fixed-point constants, the CORDIC arctangent table and a shared type.
// Used by qoa_mul and quaternion_orientation_accumulator.
`default_nettype none
package qoa_pkg;
  localparam int QW = 32;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic signed [QW-1:0] q30_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051E; 5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4; 5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55; 5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] asr64(input logic signed [63:0] v,
                                                input logic [5:0] s);
    return v >>> s;
  endfunction
endpackage
`default_nettype wire

// ----- src/qoa_mul.sv -----
// Bit-serial signed multiplier for the accumulator: one multiplier bit per cycle.
// Depends on qoa_pkg.
`default_nettype none
module qoa_mul import qoa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [33:0] a,
  input  wire logic signed [33:0] b,
  output logic                    done,
  output logic signed [67:0]      prod
);
  logic signed [67:0] acc_r, acc_nxt;
  logic signed [67:0] mcand_r, mcand_nxt;
  logic [33:0] mplier_r, mplier_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = 68'(a);
      mplier_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Top bit carries negative weight (two's complement).
      if (mplier_r[0]) begin
        if (cnt_r == 6'd33) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd33) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- src/quaternion_orientation_accumulator.sv -----
// Quaternion orientation accumulator: one rotation per item, r * o, Q1.30 out.
// Each angle of an item takes a division and a CORDIC, and each product runs on one
// bit-serial multiplier; one item at a time, the next accepted only once the result has
// been taken from out_tdata.
// Synchronous active-low reset puts the orientation at identity (w = 1.0). Needs qoa_pkg, qoa_mul.
`default_nettype none
module quaternion_orientation_accumulator import qoa_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata low to high: angle_x[25:0], angle_y, angle_z, axis_x, axis_y, axis_z, pad
  input  wire logic [175:0] in_tdata,
  // tuser: opcode
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata low to high: quat_x, quat_y, quat_z, quat_w
  output logic [127:0]      out_tdata
);
  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam logic [3:0] ST_IDLE = 4'd0, ST_HALF = 4'd1, ST_CORD = 4'd2,
                         ST_RSEL = 4'd3, ST_MUL = 4'd4, ST_MWAIT = 4'd5,
                         ST_OUT = 4'd6, ST_HDIV = 4'd7;

  logic [3:0] st_r, st_nxt;
  logic       op_r;
  logic signed [25:0] ang_r [3];
  logic signed [31:0] axis_r [3];
  logic signed [31:0] ori_r [4];
  logic signed [31:0] cs_r [3], sn_r [3];
  logic signed [31:0] rq_r [4];
  logic [1:0] ai_r;
  // CORDIC
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [5:0] ci_r;
  logic cneg_r;
  // half-angle restoring division by 360
  logic [40:0] num_r;
  logic [8:0] rem_r;
  logic [5:0] dcnt_r;
  logic hneg_r;
  // products
  logic [4:0] pi_r;
  logic signed [33:0] ma, mb;
  logic mstart, mdone;
  logic signed [67:0] mprod;
  logic signed [33:0] t_r;
  logic signed [35:0] sum_r [4];
  logic signed [33:0] mrnd;

  qoa_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod));

  assign mrnd = 34'((mprod + 68'sd536870912) >>> 30);

  function automatic logic signed [31:0] sat(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return SAT_MAX;
    if (v < -36'sd2147483648) return SAT_MIN;
    return v[31:0];
  endfunction

  // Product schedule: Euler phase uses 16 products (8 triples), then 16 Hamilton.
  // Selection codes: 0..2 cos, 3..5 sin, 6 temp, 7..9 axis, 10..13 r, 14..17 o.
  logic [4:0] sa, sb;
  logic [1:0] dst;   // destination sum
  logic       neg, first, eul;
  always_comb begin
    sa = 5'd0; sb = 5'd0; dst = 2'd0; neg = 1'b0; first = 1'b0; eul = 1'b1;
    case (pi_r)
      // triples a*b then *c; first of pair loads temp
      5'd0:  begin sa = 5'd2; sb = 5'd1; end
      5'd1:  begin sa = 5'd6; sb = 5'd3; dst = 2'd0; first = 1'b1; end
      5'd2:  begin sa = 5'd5; sb = 5'd4; end
      5'd3:  begin sa = 5'd6; sb = 5'd0; dst = 2'd0; neg = 1'b1; end
      5'd4:  begin sa = 5'd2; sb = 5'd4; end
      5'd5:  begin sa = 5'd6; sb = 5'd0; dst = 2'd1; first = 1'b1; end
      5'd6:  begin sa = 5'd5; sb = 5'd1; end
      5'd7:  begin sa = 5'd6; sb = 5'd3; dst = 2'd1; end
      5'd8:  begin sa = 5'd5; sb = 5'd1; end
      5'd9:  begin sa = 5'd6; sb = 5'd0; dst = 2'd2; first = 1'b1; end
      5'd10: begin sa = 5'd2; sb = 5'd4; end
      5'd11: begin sa = 5'd6; sb = 5'd3; dst = 2'd2; neg = 1'b1; end
      5'd12: begin sa = 5'd2; sb = 5'd1; end
      5'd13: begin sa = 5'd6; sb = 5'd0; dst = 2'd3; first = 1'b1; end
      5'd14: begin sa = 5'd5; sb = 5'd4; end
      5'd15: begin sa = 5'd6; sb = 5'd3; dst = 2'd3; end
      default: begin
        eul = 1'b0;
        // Hamilton: index h = pi-16, component c = h/4, term t = h%4
        case (pi_r[3:0])
          4'd0:  begin sa = 5'd13; sb = 5'd14; dst = 2'd0; first = 1'b1; end
          4'd1:  begin sa = 5'd10; sb = 5'd17; dst = 2'd0; end
          4'd2:  begin sa = 5'd11; sb = 5'd16; dst = 2'd0; end
          4'd3:  begin sa = 5'd12; sb = 5'd15; dst = 2'd0; neg = 1'b1; end
          4'd4:  begin sa = 5'd13; sb = 5'd15; dst = 2'd1; first = 1'b1; end
          4'd5:  begin sa = 5'd10; sb = 5'd16; dst = 2'd1; neg = 1'b1; end
          4'd6:  begin sa = 5'd11; sb = 5'd17; dst = 2'd1; end
          4'd7:  begin sa = 5'd12; sb = 5'd14; dst = 2'd1; end
          4'd8:  begin sa = 5'd13; sb = 5'd16; dst = 2'd2; first = 1'b1; end
          4'd9:  begin sa = 5'd10; sb = 5'd15; dst = 2'd2; end
          4'd10: begin sa = 5'd11; sb = 5'd14; dst = 2'd2; neg = 1'b1; end
          4'd11: begin sa = 5'd12; sb = 5'd17; dst = 2'd2; end
          4'd12: begin sa = 5'd13; sb = 5'd17; dst = 2'd3; first = 1'b1; end
          4'd13: begin sa = 5'd10; sb = 5'd14; dst = 2'd3; neg = 1'b1; end
          4'd14: begin sa = 5'd11; sb = 5'd15; dst = 2'd3; neg = 1'b1; end
          default: begin sa = 5'd12; sb = 5'd16; dst = 2'd3; neg = 1'b1; end
        endcase
      end
    endcase
  end

  function automatic logic signed [33:0] pick(input logic [4:0] s,
      input logic signed [31:0] c0, input logic signed [31:0] c1,
      input logic signed [31:0] c2, input logic signed [31:0] s0,
      input logic signed [31:0] s1, input logic signed [31:0] s2,
      input logic signed [33:0] t,
      input logic signed [31:0] x0, input logic signed [31:0] x1,
      input logic signed [31:0] x2,
      input logic signed [31:0] r0, input logic signed [31:0] r1,
      input logic signed [31:0] r2, input logic signed [31:0] r3,
      input logic signed [31:0] o0, input logic signed [31:0] o1,
      input logic signed [31:0] o2, input logic signed [31:0] o3);
    logic signed [33:0] v;
    case (s)
      5'd0: v = 34'(c0); 5'd1: v = 34'(c1); 5'd2: v = 34'(c2);
      5'd3: v = 34'(s0); 5'd4: v = 34'(s1); 5'd5: v = 34'(s2);
      5'd6: v = t;
      5'd7: v = 34'(x0); 5'd8: v = 34'(x1); 5'd9: v = 34'(x2);
      5'd10: v = 34'(r0); 5'd11: v = 34'(r1); 5'd12: v = 34'(r2);
      5'd13: v = 34'(r3);
      5'd14: v = 34'(o0); 5'd15: v = 34'(o1); 5'd16: v = 34'(o2);
      5'd17: v = 34'(o3);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Axis mode: pi 0..2 are taken over by a separate small schedule (axis * sin).
  logic [4:0] sa_e, sb_e;
  always_comb begin
    sa_e = sa; sb_e = sb;
    if (op_r && (st_r == ST_MUL || st_r == ST_MWAIT) && pi_r < 5'd3) begin
      sa_e = 5'd7 + pi_r; sb_e = 5'd3;
    end
  end

  assign ma = pick(sa_e, cs_r[0], cs_r[1], cs_r[2], sn_r[0], sn_r[1], sn_r[2], t_r,
                   axis_r[0], axis_r[1], axis_r[2], rq_r[0], rq_r[1], rq_r[2], rq_r[3],
                   ori_r[0], ori_r[1], ori_r[2], ori_r[3]);
  assign mb = pick(sb_e, cs_r[0], cs_r[1], cs_r[2], sn_r[0], sn_r[1], sn_r[2], t_r,
                   axis_r[0], axis_r[1], axis_r[2], rq_r[0], rq_r[1], rq_r[2], rq_r[3],
                   ori_r[0], ori_r[1], ori_r[2], ori_r[3]);
  assign mstart = (st_r == ST_MUL);

  // CORDIC step values
  logic signed [33:0] ydx, xdy;
  logic signed [33:0] atn;
  assign ydx = cy_r >>> ci_r;
  assign xdy = cx_r >>> ci_r;
  assign atn = 34'(signed'({1'b0, atan_lut(ci_r[4:0])}));

  logic [25:0] aabs;
  assign aabs = ang_r[ai_r][25] ? 26'(-ang_r[ai_r]) : ang_r[ai_r];
  logic [9:0] rsh;
  assign rsh = {rem_r, num_r[40]};
  logic [31:0] qv, qs;
  assign qv = num_r[31:0];
  assign qs = hneg_r ? 32'(-qv) : qv;
  logic signed [32:0] aw, af;
  logic fneg;
  always_comb begin
    aw = 33'(signed'(qs));
    fneg = 1'b0; af = aw;
    if (aw > 33'sd1073741824) begin af = 33'sd2147483648 - aw; fneg = 1'b1; end
    else if (aw < -33'sd1073741824) begin af = -33'sd2147483648 - aw; fneg = 1'b1; end
  end

  logic out_v_r;
  logic [1:0] ai_last;
  assign ai_last = op_r ? 2'd0 : 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; out_v_r <= 1'b0;
      ori_r[0] <= '0; ori_r[1] <= '0; ori_r[2] <= '0; ori_r[3] <= Q30_ONE;
    end else begin
      case (st_r)
        ST_IDLE: if (in_tvalid) begin
          op_r <= in_tuser[0];
          ang_r[0] <= in_tdata[25:0];
          ang_r[1] <= in_tdata[51:26];
          ang_r[2] <= in_tdata[77:52];
          axis_r[0] <= in_tdata[109:78];
          axis_r[1] <= in_tdata[141:110];
          axis_r[2] <= in_tdata[173:142];
          ai_r <= 2'd0; st_r <= ST_HALF;
        end
        ST_HALF: begin
          // numerator = |v|*32768 + 180, divided by 360 one bit per cycle
          hneg_r <= ang_r[ai_r][25];
          num_r <= {aabs, 15'd0} + 41'd180;
          rem_r <= '0; dcnt_r <= '0; st_r <= ST_HDIV;
        end
        ST_HDIV: begin
          if (rsh >= 10'd360) begin
            rem_r <= 9'(rsh - 10'd360); num_r <= {num_r[39:0], 1'b1};
          end else begin
            rem_r <= rsh[8:0]; num_r <= {num_r[39:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd40) begin
            st_r <= ST_CORD; ci_r <= 6'd63;
          end
        end
        ST_CORD: begin
          if (ci_r == 6'd63) begin
            cx_r <= 34'(CORDIC_GAIN); cy_r <= '0; cz_r <= 34'(af);
            cneg_r <= fneg; ci_r <= '0;
          end else if (ci_r < 6'(NSTEP)) begin
            if (!cz_r[33]) begin
              cx_r <= cx_r - ydx; cy_r <= cy_r + xdy; cz_r <= cz_r - atn;
            end else begin
              cx_r <= cx_r + ydx; cy_r <= cy_r - xdy; cz_r <= cz_r + atn;
            end
            ci_r <= ci_r + 6'd1;
          end else begin
            cs_r[ai_r] <= cneg_r ? 32'(-cx_r) : cx_r[31:0];
            sn_r[ai_r] <= cy_r[31:0];
            if (ai_r == ai_last) begin
              pi_r <= 5'd0; st_r <= ST_MUL;
            end else begin
              ai_r <= ai_r + 2'd1; st_r <= ST_HALF;
            end
          end
        end
        ST_MUL: st_r <= ST_MWAIT;
        ST_MWAIT: if (mdone) begin
          if (op_r && pi_r < 5'd3) begin
            rq_r[pi_r[1:0]] <= sat(36'(mrnd));
            if (pi_r == 5'd2) begin
              rq_r[3] <= cs_r[0]; pi_r <= 5'd16;
            end else pi_r <= pi_r + 5'd1;
            st_r <= ST_MUL;
          end else begin
            if (eul && !pi_r[0]) t_r <= mrnd;
            else if (first) sum_r[dst] <= neg ? -36'(mrnd) : 36'(mrnd);
            else sum_r[dst] <= neg ? sum_r[dst] - 36'(mrnd) : sum_r[dst] + 36'(mrnd);
            st_r <= ST_MUL;
            if (pi_r == 5'd15) begin
              pi_r <= 5'd31;
              st_r <= ST_RSEL;
            end else if (pi_r == 5'd31 && !eul) st_r <= ST_OUT;
            else pi_r <= pi_r + 5'd1;
          end
        end
        ST_RSEL: begin
          // sum_r[3] written on the last triple lands this cycle
          rq_r[0] <= sat(sum_r[0]); rq_r[1] <= sat(sum_r[1]);
          rq_r[2] <= sat(sum_r[2]); rq_r[3] <= sat(sum_r[3]);
          pi_r <= 5'd16; st_r <= ST_MUL;
        end
        ST_OUT: begin
          if (!out_v_r) begin
            ori_r[0] <= sat(sum_r[0]); ori_r[1] <= sat(sum_r[1]);
            ori_r[2] <= sat(sum_r[2]); ori_r[3] <= sat(sum_r[3]);
            out_v_r <= 1'b1;
          end else if (out_tready) begin
            out_v_r <= 1'b0; st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = {ori_r[3], ori_r[2], ori_r[1], ori_r[0]};

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !in_tready) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r) else $error("result dropped");
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CORD) |-> (ci_r <= 6'(NSTEP) || ci_r == 6'd63)) else $error("cordic index");
endmodule
`default_nettype wire
